/* sv/ttip_pkg.sv */
package ttip_pkg;

  localparam int unsigned MAX_CHARS_DEF = 4095;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned BASE_W = 6;
  localparam int unsigned CHAR_W = 8;

  // Largest count that the result field can show.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_NUMBER_BASE = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_idx_t;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_TWO   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] LETTER_OFS = 6'd10;

  localparam logic [VAL_W-1:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] SMIN_MAG = 64'h8000_0000_0000_0000;
  localparam logic [VAL_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  // How a zero (auto) base is resolved for a digit taken in this cycle.
  typedef enum logic [1:0] {
    DB_KEEP = 2'd0,
    DB_DEC  = 2'd1,
    DB_OCT  = 2'd2
  } db_t;

  typedef struct packed {
    logic fire;       // a character transaction completes
    logic last;       // it is the final character: capture and clear
    logic load_sign;  // take the sign character
    logic mark_zero;  // a leading zero counts as the number so far
    logic take;       // accumulate the digit
    logic eb_commit;  // store the resolved base
    logic set_hex;    // a 0x prefix was taken
    db_t  db;
  } ttip_cmd_t;

  typedef struct packed {
    logic first;        // first character of a string
    logic base_bad;     // base in force is 1 or above 36
    logic auto_or_hex;  // base in force is 0 or 16
    logic c_blank;
    logic c_plus;
    logic c_minus;
    logic c_zero;
    logic c_x;
    logic digit_ok;     // digit is valid in the resolved base
  } ttip_sts_t;

endpackage

/* sv/ttip_ctrl.sv */
module ttip_ctrl
  import ttip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_char,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ttip_sts_t sts,
  output ttip_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_SKIP   = 6'b000001,
    ST_SIGN   = 6'b000010,
    ST_ZERO   = 6'b000100,
    ST_HEXX   = 6'b001000,
    ST_DIGITS = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fire;

  // A character that ends a string needs room in the result register.
  assign in_ready  = !out_valid_r || out_ready || !in_last_char;
  assign fire      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    logic start_num;
    logic try_digit;
    start_num = 1'b0;
    try_digit = 1'b0;
    state_nxt = state_r;
    cmd       = '0;
    cmd.fire  = fire;
    cmd.last  = fire && in_last_char;

    case (state_r)
      ST_SKIP, ST_SIGN: cmd.db = DB_DEC;
      ST_ZERO:          cmd.db = DB_OCT;
      default:          cmd.db = DB_KEEP;
    endcase

    if (fire) begin
      if (sts.first && sts.base_bad) begin
        state_nxt = ST_DONE;
      end else begin
        case (state_r)
          ST_SKIP: begin
            if (sts.c_blank) begin
              state_nxt = ST_SKIP;
            end else if (sts.c_plus || sts.c_minus) begin
              cmd.load_sign = 1'b1;
              state_nxt     = ST_SIGN;
            end else begin
              start_num = 1'b1;
            end
          end
          ST_SIGN: begin
            start_num = 1'b1;
          end
          ST_ZERO: begin
            if (sts.c_x) begin
              cmd.set_hex = 1'b1;
              state_nxt   = ST_HEXX;
            end else begin
              cmd.eb_commit = 1'b1;
              try_digit     = 1'b1;
            end
          end
          ST_HEXX, ST_DIGITS: begin
            try_digit = 1'b1;
          end
          ST_DONE: begin
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_SKIP;
          end
        endcase
      end

      if (start_num) begin
        if (sts.auto_or_hex && sts.c_zero) begin
          cmd.mark_zero = 1'b1;
          state_nxt     = ST_ZERO;
        end else begin
          cmd.eb_commit = 1'b1;
          try_digit     = 1'b1;
        end
      end

      if (try_digit) begin
        if (sts.digit_ok) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DIGITS;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      if (in_last_char) begin
        state_nxt = ST_SKIP;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire && in_last_char) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SKIP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_char) |-> (!out_valid_r || out_ready))
    else $error("final character accepted while a result is still held");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_char) |=> (state_r == ST_SKIP))
    else $error("parser did not return to whitespace skipping after a string");

  a_mid_string_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_last_char) |-> in_ready)
    else $error("a character inside a string was stalled");

endmodule

/* sv/ttip_dpath.sv */
module ttip_dpath
  import ttip_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_wdata,
  input  logic [CHAR_W-1:0] in_character,
  input  ttip_cmd_t         cmd,
  output ttip_sts_t         sts,
  output logic [VAL_W-1:0]  out_value,
  output logic [CNT_W-1:0]  out_consumed_count,
  output logic              out_negative,
  output logic              out_overflow,
  output logic              out_invalid_base
);

  localparam int unsigned PW   = $clog2(MAX_CHARS + 1);
  localparam int unsigned EW   = (PW > CNT_W) ? PW : CNT_W;
  localparam int unsigned PR_W = VAL_W + BASE_W;
  localparam int unsigned SU_W = PR_W + 1;

  // Configuration registers.
  logic [BASE_W-1:0] base_cfg_r;
  logic              signed_r;

  // Per-string state.
  logic [VAL_W-1:0]  acc_r, acc_upd;
  logic              minus_r, minus_upd;
  logic              ovf_r, ovf_upd;
  logic              digit_r, digit_upd;
  logic [BASE_W-1:0] eb_r, eb_upd;
  logic [PW-1:0]     pos_r, npos;
  logic [PW-1:0]     endp_r, endp_upd;

  // Result register.
  logic [VAL_W-1:0]  res_acc_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic              res_neg_r;
  logic              res_ovf_r;
  logic              res_sgn_r;
  logic              res_inv_r;

  logic [BASE_W-1:0] base_in, base_use, dval;
  logic              is_dig, base_bad_upd;
  logic [VAL_W-1:0]  limit;
  logic [PR_W-1:0]   prod;
  logic [SU_W-1:0]   sum;
  logic              over;
  logic [EW-1:0]     end_ext;
  logic [CNT_W-1:0]  cnt_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r <= BASE_RESET;
      signed_r   <= 1'b1;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_NUMBER_BASE: base_cfg_r <= cfg_wdata;
        REG_SIGNED_MODE: signed_r   <= cfg_wdata[0];
        default:         signed_r   <= signed_r;
      endcase
    end
  end

  // Character classes and digit value.
  always_comb begin
    is_dig = 1'b1;
    dval   = '0;
    if (in_character >= CH_ZERO && in_character <= CH_NINE) begin
      dval = BASE_W'(in_character - CH_ZERO);
    end else if (in_character >= CH_LA && in_character <= CH_LZ) begin
      dval = BASE_W'(in_character - CH_LA) + LETTER_OFS;
    end else if (in_character >= CH_UA && in_character <= CH_UZ) begin
      dval = BASE_W'(in_character - CH_UA) + LETTER_OFS;
    end else begin
      is_dig = 1'b0;
    end
  end

  assign base_in = sts.first ? base_cfg_r : eb_r;

  always_comb begin
    base_use = base_in;
    if (base_in == BASE_AUTO && cmd.db == DB_DEC) begin
      base_use = BASE_DEC;
    end else if (base_in == BASE_AUTO && cmd.db == DB_OCT) begin
      base_use = BASE_OCT;
    end
  end

  assign sts.first       = (pos_r == '0);
  assign sts.base_bad    = (base_in == BASE_ONE) || (base_in > BASE_MAX);
  assign sts.auto_or_hex = (base_in == BASE_AUTO) || (base_in == BASE_HEX);
  assign sts.c_blank     = (in_character == CH_SPACE) ||
                           (in_character >= CH_TAB && in_character <= CH_CR);
  assign sts.c_plus      = (in_character == CH_PLUS);
  assign sts.c_minus     = (in_character == CH_MINUS);
  assign sts.c_zero      = (in_character == CH_ZERO);
  assign sts.c_x         = (in_character == CH_LX) || (in_character == CH_UX);
  assign sts.digit_ok    = is_dig && (base_use >= BASE_TWO) && (dval < base_use);

  // acc * base + digit exceeds the limit exactly when the digit overflows.
  always_comb begin
    if (signed_r) begin
      limit = minus_r ? SMIN_MAG : SMAX;
    end else begin
      limit = ALL_ONES;
    end
  end

  assign prod = PR_W'(acc_r) * PR_W'(base_use);
  assign sum  = SU_W'(prod) + SU_W'(dval);
  assign over = sum > SU_W'(limit);

  always_comb begin
    acc_upd = acc_r;
    ovf_upd = ovf_r;
    if (cmd.take) begin
      if (over) begin
        ovf_upd = 1'b1;
        acc_upd = limit;
      end else if (!ovf_r) begin
        acc_upd = sum[VAL_W-1:0];
      end
    end
  end

  assign npos      = (pos_r < PW'(MAX_CHARS)) ? pos_r + 1'b1 : PW'(MAX_CHARS);
  assign minus_upd = cmd.load_sign ? sts.c_minus : minus_r;
  assign digit_upd = (cmd.mark_zero || cmd.take) ? 1'b1 : digit_r;
  assign endp_upd  = (cmd.mark_zero || cmd.take) ? npos : endp_r;

  always_comb begin
    if (cmd.set_hex) begin
      eb_upd = BASE_HEX;
    end else if (cmd.eb_commit) begin
      eb_upd = base_use;
    end else begin
      eb_upd = base_in;
    end
  end

  assign base_bad_upd = (eb_upd == BASE_ONE) || (eb_upd > BASE_MAX);
  assign end_ext      = EW'(endp_upd);
  always_comb begin
    if (!digit_upd || base_bad_upd) begin
      cnt_upd = '0;
    end else if (end_ext > EW'(CNT_MAX)) begin
      cnt_upd = CNT_MAX;
    end else begin
      cnt_upd = end_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      minus_r <= 1'b0;
      ovf_r   <= 1'b0;
      digit_r <= 1'b0;
      eb_r    <= '0;
      pos_r   <= '0;
      endp_r  <= '0;
    end else if (cmd.fire) begin
      if (cmd.last) begin
        acc_r   <= '0;
        minus_r <= 1'b0;
        ovf_r   <= 1'b0;
        digit_r <= 1'b0;
        eb_r    <= '0;
        pos_r   <= '0;
        endp_r  <= '0;
      end else begin
        acc_r   <= acc_upd;
        minus_r <= minus_upd;
        ovf_r   <= ovf_upd;
        digit_r <= digit_upd;
        eb_r    <= eb_upd;
        pos_r   <= npos;
        endp_r  <= endp_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.last) begin
      res_acc_r <= acc_upd;
      res_cnt_r <= cnt_upd;
      res_neg_r <= minus_upd && !base_bad_upd;
      res_ovf_r <= ovf_upd && !base_bad_upd;
      res_sgn_r <= signed_r;
      res_inv_r <= base_bad_upd;
    end
  end

  always_comb begin
    if (res_inv_r) begin
      out_value = '0;
    end else if (res_ovf_r) begin
      if (res_sgn_r) begin
        out_value = res_neg_r ? SMIN_MAG : SMAX;
      end else begin
        out_value = ALL_ONES;
      end
    end else if (res_neg_r) begin
      out_value = '0 - res_acc_r;
    end else begin
      out_value = res_acc_r;
    end
  end

  assign out_consumed_count = res_cnt_r;
  assign out_negative       = res_neg_r;
  assign out_overflow       = res_ovf_r;
  assign out_invalid_base   = res_inv_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |=> (pos_r == '0) && !ovf_r && !digit_r)
    else $error("string state not cleared after the final character");

  a_overflow_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> digit_r)
    else $error("overflow recorded without any digit");

endmodule

/* sv/text_to_integer_parser.sv */
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_wdata
// in       in         in_valid / in_ready    in_character, in_last_char
// out      out        out_valid / out_ready  out_value, out_consumed_count,
//                                            out_negative, out_overflow,
//                                            out_invalid_base
//
// One character is taken per clock cycle while no final character waits;
// the digit step (one 64 by 6 bit multiply-add and a limit compare) sets that.
// The result of a string is held in the output register from the cycle after
// its final character transaction until the result transaction completes.
// Characters inside a string are never stalled; a final character waits only
// while an earlier result is still held and not being taken in that cycle.
// Reset is synchronous and active low; it clears the parser and sets the
// base to ten and the mode to signed. Configuration writes complete at once.
module text_to_integer_parser
  import ttip_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_wdata,
  // Character stream.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_character,
  input  logic              in_last_char,
  // Results, one per string.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  out_value,
  output logic [CNT_W-1:0]  out_consumed_count,
  output logic              out_negative,
  output logic              out_overflow,
  output logic              out_invalid_base
);

  ttip_cmd_t cmd;
  ttip_sts_t sts;

  // The registers are plain storage, so a write transaction is never held off.
  assign cfg_ready = 1'b1;

  // The controller follows the phase of the string: whitespace, sign, a
  // leading zero that may open a hex prefix, the prefix itself, digits, and
  // the finished state in which the rest of the string is only counted.
  ttip_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // The datapath classifies each character, keeps the accumulator with its
  // overflow limit, the base in force and the position counters, and holds
  // the result register from which the signed or unsigned value is formed.
  ttip_dpath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_character       (in_character),
    .cmd                (cmd),
    .sts                (sts),
    .out_value          (out_value),
    .out_consumed_count (out_consumed_count),
    .out_negative       (out_negative),
    .out_overflow       (out_overflow),
    .out_invalid_base   (out_invalid_base)
  );

endmodule
